// File: hdl/stc_pkg.sv
// Package for the string type checker: payload types, character codes and check result type.
`default_nettype none

package stc_pkg;

   // Input item: one character of a field plus the field framing
   typedef struct packed {
      logic [7:0]  chr;
      logic        first;
      logic        last;
      logic [7:0]  check_kind;
      logic [15:0] base_position;
   } req_payload_type;

   // Result item: verdict and first mismatch position
   typedef struct packed {
      logic [1:0]  verdict;
      logic [15:0] fail_position;
   } rsp_payload_type;

   // Verdict codes
   localparam logic [1:0] VERDICT_OK       = 2'd0;
   localparam logic [1:0] VERDICT_MISMATCH = 2'd1;
   localparam logic [1:0] VERDICT_BAD_KIND = 2'd2;

   // Type letters (upper case)
   localparam logic [7:0] KIND_INT   = 8'h49; // I
   localparam logic [7:0] KIND_REAL  = 8'h52; // R
   localparam logic [7:0] KIND_ALNUM = 8'h41; // A
   localparam logic [7:0] KIND_ALPHA = 8'h4C; // L
   localparam logic [7:0] KIND_NUM   = 8'h4E; // N
   localparam logic [7:0] KIND_PRINT = 8'h50; // P
   localparam logic [7:0] KIND_SPEC  = 8'h53; // S
   localparam logic [7:0] KIND_UNDIG = 8'h55; // U

   // Characters with a role in number fields
   localparam logic [7:0] CHR_SPACE  = 8'h20;
   localparam logic [7:0] CHR_PLUS   = 8'h2B;
   localparam logic [7:0] CHR_MINUS  = 8'h2D;
   localparam logic [7:0] CHR_PERIOD = 8'h2E;

   // Number field phases
   localparam logic [1:0] PH_LEAD   = 2'd0;
   localparam logic [1:0] PH_SIGN   = 2'd1;
   localparam logic [1:0] PH_DIGITS = 2'd2;
   localparam logic [1:0] PH_TRAIL  = 2'd3;

   // Outcome of checking one character
   typedef struct packed {
      logic       fits;
      logic       digit_hit;
      logic [1:0] phase_next;
      logic       period_next;
   } check_result_type;

endpackage

`default_nettype wire

// File: hdl/stc_char_check.sv
// Character classifier: checks one character against the held type, advances the number phase.
`default_nettype none

module stc_char_check
   import stc_pkg::*;
(
   input  wire logic [7:0]       chr,
   input  wire logic [7:0]       kind,
   input  wire logic [1:0]       phase,
   input  wire logic             period_seen,
   output check_result_type     result
);

   logic is_dig;
   logic is_let;
   logic is_prt;
   logic is_sp;
   logic is_sign;
   logic is_dot;
   check_result_type num_res;

   // ASCII classes
   always_comb begin
      is_dig  = (chr >= 8'h30) && (chr <= 8'h39);
      is_let  = ((chr >= 8'h41) && (chr <= 8'h5A)) || ((chr >= 8'h61) && (chr <= 8'h7A));
      is_prt  = (chr >= 8'h20) && (chr <= 8'h7E);
      is_sp   = (chr == CHR_SPACE);
      is_sign = (chr == CHR_PLUS) || (chr == CHR_MINUS);
      is_dot  = (kind == KIND_REAL) && (chr == CHR_PERIOD);
   end

   // Integer / real phase machine
   always_comb begin
      logic common;
      common = 1'b0;
      num_res = '{fits: 1'b0, digit_hit: 1'b0, phase_next: phase, period_next: period_seen};
      unique case (phase) inside
         PH_LEAD: begin
            if (is_sp) begin
               num_res.fits = 1'b1;
            end else if (is_sign) begin
               num_res.fits = 1'b1;
               num_res.phase_next = PH_SIGN;
            end else begin
               common = 1'b1;
            end
         end
         PH_SIGN, PH_DIGITS: begin
            if (is_sp) begin
               num_res.fits = 1'b1;
               num_res.phase_next = PH_TRAIL;
            end else begin
               common = 1'b1;
            end
         end
         default: begin
            num_res.fits = is_sp;
         end
      endcase
      // digits and the single period
      if (common) begin
         if (is_dig) begin
            num_res.fits = 1'b1;
            num_res.digit_hit = 1'b1;
            num_res.phase_next = PH_DIGITS;
         end else if (is_dot && !period_seen) begin
            num_res.fits = 1'b1;
            num_res.period_next = 1'b1;
            num_res.phase_next = PH_DIGITS;
         end
      end
   end

   // Select by type letter
   always_comb begin
      result = '{fits: 1'b1, digit_hit: 1'b0, phase_next: phase, period_next: period_seen};
      unique case (kind) inside
         KIND_INT, KIND_REAL: result = num_res;
         KIND_ALNUM:          result.fits = is_let || is_dig;
         KIND_ALPHA:          result.fits = is_let;
         KIND_NUM:            result.fits = is_dig;
         KIND_PRINT:          result.fits = is_prt;
         KIND_SPEC:           result.fits = !(is_let || is_dig);
         KIND_UNDIG:          result.fits = is_prt && !is_dig;
         default:             result.fits = 1'b1;
      endcase
   end

endmodule

`default_nettype wire

// File: hdl/string_type_checker.sv
// String type checker top level: input register, per-field check state and result register.
//
// Takes one character of a text field per transfer and checks the field against a type
// letter (I R A L N P S U, any case) given with its first character. On the transfer that
// carries the last character one result comes out: OK, mismatch with the 1-based absolute
// position of the first bad character, or unknown type letter. A character is accepted every
// cycle unless a last character waits on a stalled result; it passes the input register, then
// the check and the result register. The rate is set by the combinational classifier and the
// per-field state update between them. Positions count in POSITION_BITS bits and saturate.
`default_nettype none

module string_type_checker
   import stc_pkg::*;
#(
   parameter int POSITION_BITS = 16
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output      logic            req_stall,
   input  wire req_payload_type req_payload,
   output      logic            rsp_valid,
   input  wire logic            rsp_stall,
   output      rsp_payload_type rsp_payload
);

   localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

   // Input register
   logic            s1_valid_ff, s1_valid_in;
   req_payload_type s1_ff;

   // Field state
   logic [7:0]               kind_ff, kind_in;
   logic [POSITION_BITS-1:0] offset_ff, offset_in;
   logic [1:0]               phase_ff, phase_in;
   logic                     period_ff, period_in;
   logic                     digit_ff, digit_in;
   logic                     failed_ff, failed_in;
   logic [POSITION_BITS-1:0] first_fail_ff, first_fail_in;

   // Result register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   logic                     out_free;
   logic                     s1_adv;
   logic [7:0]               kind_up;
   logic                     base_big;
   logic [POSITION_BITS-1:0] base_clip;
   logic [7:0]               kind_eff;
   logic [POSITION_BITS-1:0] offset_eff;
   logic [1:0]               phase_eff;
   logic                     period_eff;
   logic                     digit_eff;
   logic                     failed_eff;
   logic [POSITION_BITS-1:0] first_fail_eff;
   logic                     known;
   logic                     active;
   check_result_type         chk;

   // Handshake
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign s1_adv      = s1_valid_ff && (!s1_ff.last || out_free);
   assign req_stall   = s1_valid_ff && !s1_adv;
   assign s1_valid_in = req_valid ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);

   // Field start: upper-case the letter and clip the base offset
   always_comb begin
      kind_up = s1_ff.check_kind;
      if ((s1_ff.check_kind >= 8'h61) && (s1_ff.check_kind <= 8'h7A)) begin
         kind_up = s1_ff.check_kind - 8'h20;
      end
      base_big  = (s1_ff.base_position >> POSITION_BITS) != 16'd0;
      base_clip = base_big ? POS_MAX : POSITION_BITS'(s1_ff.base_position);
   end

   // State as seen by this character
   always_comb begin
      if (s1_ff.first) begin
         kind_eff       = kind_up;
         offset_eff     = base_clip;
         phase_eff      = PH_LEAD;
         period_eff     = 1'b0;
         digit_eff      = 1'b0;
         failed_eff     = 1'b0;
         first_fail_eff = '0;
      end else begin
         kind_eff       = kind_ff;
         offset_eff     = offset_ff;
         phase_eff      = phase_ff;
         period_eff     = period_ff;
         digit_eff      = digit_ff;
         failed_eff     = failed_ff;
         first_fail_eff = first_fail_ff;
      end
   end

   stc_char_check u_char_check (
      .chr         (s1_ff.chr),
      .kind        (kind_eff),
      .phase       (phase_eff),
      .period_seen (period_eff),
      .result      (chk)
   );

   // Next field state
   always_comb begin
      unique case (kind_eff) inside
         KIND_INT, KIND_REAL, KIND_ALNUM, KIND_ALPHA,
         KIND_NUM, KIND_PRINT, KIND_SPEC, KIND_UNDIG: known = 1'b1;
         default:                                     known = 1'b0;
      endcase
      active     = known && !failed_eff;
      kind_in    = kind_eff;
      // saturating offset; also the 1-based position of this character
      offset_in  = (offset_eff < POS_MAX) ? offset_eff + 1'b1 : offset_eff;
      phase_in   = active ? chk.phase_next : phase_eff;
      period_in  = active ? chk.period_next : period_eff;
      digit_in   = digit_eff || (active && chk.digit_hit);
      failed_in  = failed_eff || (active && !chk.fits);
      first_fail_in = (active && !chk.fits) ? offset_in : first_fail_eff;
   end

   // Result for the last character
   always_comb begin
      if (!known) begin
         rsp_in = '{verdict: VERDICT_BAD_KIND, fail_position: 16'd0};
      end else if (failed_in) begin
         rsp_in = '{verdict: VERDICT_MISMATCH, fail_position: 16'(first_fail_in)};
      end else if (((kind_eff == KIND_INT) || (kind_eff == KIND_REAL)) && !digit_in) begin
         rsp_in = '{verdict: VERDICT_MISMATCH, fail_position: 16'd1};
      end else begin
         rsp_in = '{verdict: VERDICT_OK, fail_position: 16'd0};
      end
      rsp_valid_in = out_free ? (s1_adv && s1_ff.last) : rsp_valid_ff;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         kind_ff       <= '0;
         offset_ff     <= '0;
         phase_ff      <= PH_LEAD;
         period_ff     <= 1'b0;
         digit_ff      <= 1'b0;
         failed_ff     <= 1'b0;
         first_fail_ff <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_adv) begin
            kind_ff       <= kind_in;
            offset_ff     <= offset_in;
            phase_ff      <= phase_in;
            period_ff     <= period_in;
            digit_ff      <= digit_in;
            failed_ff     <= failed_in;
            first_fail_ff <= first_fail_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_ff <= req_payload;
      end
      if (out_free && s1_adv && s1_ff.last) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Assertions
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("input stalled with an empty input register");

   a_fail_pos_nonzero: assert property (@(posedge clock) disable iff (reset)
      failed_ff |-> (first_fail_ff != '0))
      else $error("mismatch recorded without a position");

   a_ok_no_position: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.verdict == VERDICT_OK)) |->
         (rsp_payload.fail_position == 16'd0))
      else $error("OK verdict carries a position");

   a_phase_frozen: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && failed_ff && !s1_ff.first) |=> (phase_ff == $past(phase_ff)))
      else $error("number phase moved after a mismatch");

endmodule

`default_nettype wire

// File: test/string_type_checker_tb.sv
// Self-checking testbench for the string type checker: stimulus, prediction and result check.
`default_nettype none

module string_type_checker_tb
   import stc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1100;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 10;
   localparam logic [15:0] POS_MAX = 16'hFFFF;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_payload;

   string_type_checker #(.POSITION_BITS(16)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // Characters waiting to be sent and verdicts waiting to come back
   req_payload_type char_queue[$];
   rsp_payload_type verdict_queue[$];
   logic [7:0]      field_text[$];

   int total_chars;
   int chars_issued;
   int chars_taken;
   int cycle_count;
   int mismatch_count;
   int ok_seen, bad_seen, unknown_seen;
   int hold_left;
   bit hold_done;
   bit req_fire;

   // Shadow of the checker's per-field state
   logic [7:0]  kind_q;
   logic [15:0] offs_q;
   logic [1:0]  phase_q;
   bit          period_q, digit_q, failed_q;
   logic [15:0] ffail_q;

   logic [7:0] kind_list[8] = '{KIND_INT, KIND_REAL, KIND_ALNUM, KIND_ALPHA,
                                KIND_NUM, KIND_PRINT, KIND_SPEC, KIND_UNDIG};

   always #1 clock = ~clock;

   function automatic bit is_dig(logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic bit is_let(logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic bit is_prn(logic [7:0] c);
      return c >= 8'h20 && c <= 8'h7E;
   endfunction

   function automatic bit kind_known(logic [7:0] k);
      return k == KIND_INT || k == KIND_REAL || k == KIND_ALNUM || k == KIND_ALPHA ||
             k == KIND_NUM || k == KIND_PRINT || k == KIND_SPEC || k == KIND_UNDIG;
   endfunction

   // Integer/real phase walk; returns whether the character fits
   task automatic number_fits(input logic [7:0] c, input bit real_ok, output bit ok);
      bit decided;
      decided = 0;
      ok = 0;
      case (phase_q) inside
         PH_LEAD: begin
            if (c == CHR_SPACE) begin
               ok = 1; decided = 1;
            end else if (c == CHR_PLUS || c == CHR_MINUS) begin
               phase_q = PH_SIGN; ok = 1; decided = 1;
            end
         end
         PH_SIGN, PH_DIGITS: begin
            if (c == CHR_SPACE) begin
               phase_q = PH_TRAIL; ok = 1; decided = 1;
            end
         end
         default: begin
            ok = (c == CHR_SPACE); decided = 1;
         end
      endcase
      if (!decided) begin
         if (is_dig(c)) begin
            digit_q = 1; phase_q = PH_DIGITS; ok = 1;
         end else if (real_ok && c == CHR_PERIOD && !period_q) begin
            period_q = 1; phase_q = PH_DIGITS; ok = 1;
         end
      end
   endtask

   // Advance the shadow state by one accepted character; queue a verdict on last
   task automatic predict_verdict(input req_payload_type it);
      logic [7:0]      k;
      bit              ok;
      rsp_payload_type v;
      if (it.first) begin
         k = it.check_kind;
         if (k >= 8'h61 && k <= 8'h7A) k = k - 8'h20;
         kind_q   = k;
         offs_q   = it.base_position;
         phase_q  = PH_LEAD;
         period_q = 0;
         digit_q  = 0;
         failed_q = 0;
         ffail_q  = '0;
      end
      if (kind_known(kind_q) && !failed_q) begin
         case (kind_q)
            KIND_INT:   number_fits(it.chr, 0, ok);
            KIND_REAL:  number_fits(it.chr, 1, ok);
            KIND_ALNUM: ok = is_let(it.chr) || is_dig(it.chr);
            KIND_ALPHA: ok = is_let(it.chr);
            KIND_NUM:   ok = is_dig(it.chr);
            KIND_PRINT: ok = is_prn(it.chr);
            KIND_SPEC:  ok = !(is_let(it.chr) || is_dig(it.chr));
            KIND_UNDIG: ok = is_prn(it.chr) && !is_dig(it.chr);
            default:    ok = 1;
         endcase
         if (!ok) begin
            failed_q = 1;
            ffail_q  = (offs_q == POS_MAX) ? POS_MAX : offs_q + 16'd1;
         end
      end
      if (offs_q != POS_MAX) offs_q = offs_q + 16'd1;
      if (it.last) begin
         if (!kind_known(kind_q)) begin
            v.verdict = VERDICT_BAD_KIND; v.fail_position = '0;
         end else if (failed_q) begin
            v.verdict = VERDICT_MISMATCH; v.fail_position = ffail_q;
         end else if ((kind_q == KIND_INT || kind_q == KIND_REAL) && !digit_q) begin
            // number field with no digit at all fails at position one
            v.verdict = VERDICT_MISMATCH; v.fail_position = 16'd1;
         end else begin
            v.verdict = VERDICT_OK; v.fail_position = '0;
         end
         verdict_queue.push_back(v);
      end
   endtask

   // Stimulus helpers; fields that are read only on first get random filler elsewhere
   task automatic push_char(input logic [7:0] c, input bit f, input bit l,
                            input logic [7:0] kind, input logic [15:0] base);
      req_payload_type it;
      it.chr           = c;
      it.first         = f;
      it.last          = l;
      it.check_kind    = f ? kind : 8'($urandom);
      it.base_position = f ? base : 16'($urandom);
      char_queue.push_back(it);
   endtask

   task automatic push_text(input string s, input logic [7:0] kind, input logic [15:0] base);
      for (int i = 0; i < s.len(); i++)
         push_char(s[i], i == 0, i == s.len() - 1, kind, base);
   endtask

   function automatic logic [7:0] class_char(logic [7:0] kind);
      string      punct;
      logic [7:0] c;
      punct = " !\"#$%&'()*+,-./:;<=>?@[\\]^_`{|}~";
      case (kind)
         KIND_ALNUM: begin
            case ($urandom_range(2))
               0:       c = 8'($urandom_range(8'h39, 8'h30));
               1:       c = 8'($urandom_range(8'h5A, 8'h41));
               default: c = 8'($urandom_range(8'h7A, 8'h61));
            endcase
         end
         KIND_ALPHA: c = $urandom_range(1) ? 8'($urandom_range(8'h5A, 8'h41))
                                          : 8'($urandom_range(8'h7A, 8'h61));
         KIND_NUM:   c = 8'($urandom_range(8'h39, 8'h30));
         KIND_PRINT: c = 8'($urandom_range(8'h7E, 8'h20));
         KIND_SPEC: begin
            if ($urandom_range(9) == 0) c = 8'($urandom_range(8'hFF, 8'h7F));
            else c = punct[$urandom_range(punct.len() - 1)];
         end
         KIND_UNDIG: begin
            c = 8'($urandom_range(8'h7E, 8'h20));
            while (is_dig(c)) c = 8'($urandom_range(8'h7E, 8'h20));
         end
         default: c = 8'($urandom);
      endcase
      return c;
   endfunction

   // Mostly well-formed number text: spaces, sign, digits with an optional period, spaces
   task automatic make_number(input bit real_ok);
      int ndig, dot_at;
      field_text.delete();
      repeat ($urandom_range(2)) field_text.push_back(CHR_SPACE);
      if ($urandom_range(1)) field_text.push_back($urandom_range(1) ? CHR_PLUS : CHR_MINUS);
      ndig   = ($urandom_range(9) == 0) ? 0 : $urandom_range(5, 1);
      dot_at = (real_ok && $urandom_range(1)) ? $urandom_range(ndig) : -1;
      for (int i = 0; i <= ndig; i++) begin
         if (i == dot_at) field_text.push_back(CHR_PERIOD);
         if (i < ndig) field_text.push_back(8'($urandom_range(8'h39, 8'h30)));
      end
      if (real_ok && $urandom_range(9) == 0) field_text.push_back(CHR_PERIOD);
      repeat ($urandom_range(2)) field_text.push_back(CHR_SPACE);
      if (field_text.size() == 0) field_text.push_back(CHR_SPACE);
   endtask

   task automatic push_random_field();
      logic [7:0]  kind, sent_kind;
      logic [15:0] base;
      int          len;
      bit          no_last;
      kind = kind_list[$urandom_range(7)];
      if (kind == KIND_INT || kind == KIND_REAL) begin
         make_number(kind == KIND_REAL);
      end else begin
         len = ($urandom_range(9) == 0) ? $urandom_range(24, 1) : $urandom_range(6, 1);
         field_text.delete();
         repeat (len) field_text.push_back(class_char(kind));
      end
      // corrupt one character now and then
      if ($urandom_range(3) == 0)
         field_text[$urandom_range(field_text.size() - 1)] = 8'($urandom);
      sent_kind = $urandom_range(1) ? kind : kind + 8'h20;
      if ($urandom_range(9) == 0) sent_kind = 8'($urandom);
      case ($urandom_range(9))
         0:       base = 16'($urandom_range(16'hFFFF, 16'hFFF0));
         1:       base = 16'($urandom_range(15));
         default: base = 16'($urandom);
      endcase
      no_last = ($urandom_range(19) == 0);
      for (int i = 0; i < field_text.size(); i++)
         push_char(field_text[i], i == 0, (i == field_text.size() - 1) && !no_last,
                   sent_kind, base);
   endtask

   // Input transfer and result transfer, sampled at the rising edge
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      req_fire    <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         predict_verdict(req_payload);
         chars_taken++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         case (rsp_payload.verdict)
            VERDICT_OK:       ok_seen++;
            VERDICT_MISMATCH: bad_seen++;
            default:          unknown_seen++;
         endcase
         if (verdict_queue.size() == 0) begin
            $display("%0t: unexpected result, actual verdict %0d position %0d",
                     $realtime, rsp_payload.verdict, rsp_payload.fail_position);
            mismatch_count++;
         end else begin
            if (rsp_payload.verdict !== verdict_queue[0].verdict) begin
               $display("%0t: verdict expected %0d actual %0d", $realtime,
                        verdict_queue[0].verdict, rsp_payload.verdict);
               mismatch_count++;
            end
            if (rsp_payload.fail_position !== verdict_queue[0].fail_position) begin
               $display("%0t: fail_position expected %0d actual %0d", $realtime,
                        verdict_queue[0].fail_position, rsp_payload.fail_position);
               mismatch_count++;
            end
            void'(verdict_queue.pop_front());
         end
      end
   end

   // Pacing phase from progress through the stimulus
   function automatic int pace_phase();
      if (chars_issued < total_chars / 3) return 0;
      if (chars_issued < 2 * total_chars / 3) return 1;
      return 2;
   endfunction

   // Sender: offer the next character at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (char_queue.size() != 0 &&
             $urandom_range(99) >= (pace_phase() == 0 ? 22 : pace_phase() == 1 ? 83 : 0)) begin
            req_valid   <= 1'b1;
            req_payload <= char_queue.pop_front();
            chars_issued++;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stall, plus one long hold-off early in the last phase
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && pace_phase() == 2) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= $urandom_range(99) < (pace_phase() == 0 ? 83 : pace_phase() == 1 ? 22 : 0);
      end
   end

   // Run limit
   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $realtime, verdict_queue.size());
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_stall = 1'b0;
      req_fire = 1'b0;
      cycle_count = 0;
      mismatch_count = 0;
      chars_issued = 0;
      chars_taken = 0;
      ok_seen = 0; bad_seen = 0; unknown_seen = 0;
      hold_left = 0;
      hold_done = 1'b0;
      kind_q = '0; offs_q = '0; phase_q = PH_LEAD;
      period_q = 0; digit_q = 0; failed_q = 0; ffail_q = '0;

      // Directed fields
      push_char("Z", 0, 1, KIND_ALNUM, 16'd0);       // no field started since reset
      push_text("-3 ", "i", 16'd0);                  // signed integer, trailing space
      push_text("+ ", KIND_INT, 16'd100);            // spaces after a sign, no digits
      push_text("1.2.", "r", 16'hFFFA);              // second period in a real
      push_text("  ", KIND_REAL, 16'd7);             // real without digits
      push_char(8'h41, 1, 0, KIND_PRINT, 16'hFFFF);  // position saturation
      push_char(8'hFF, 0, 1, KIND_PRINT, 16'd0);
      push_text("b9", "a", 16'd3);
      push_text("a1", "l", 16'd40);
      push_text("09", KIND_NUM, 16'd0);
      push_text("#!", "s", 16'd1);
      push_text("x0", "u", 16'd500);
      push_char("?", 0, 1, KIND_INT, 16'd0);         // continues the failed field
      push_char(8'h00, 1, 1, "q", 16'd9);            // unknown type letter

      // Random fields with some noise characters
      while (char_queue.size() < RANDOM_ITEMS + 26) begin
         if ($urandom_range(12) == 0)
            push_char(8'($urandom), 1'($urandom), 1'($urandom), 8'($urandom), 16'($urandom));
         else
            push_random_field();
      end
      // make sure a verdict closes the stream
      push_char("X", 0, 1, KIND_ALPHA, 16'd0);
      total_chars = char_queue.size();

      repeat (12) @(negedge clock);
      reset = 1'b0;

      wait (char_queue.size() == 0);
      @(negedge clock);
      while (req_valid) @(negedge clock);
      while (verdict_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d characters under three pacing phases and one long result hold-off;",
               chars_taken);
      $display("results: %0d ok, %0d mismatch, %0d unknown letter", ok_seen, bad_seen,
               unknown_seen);
      if (mismatch_count == 0 && verdict_queue.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire
